// ===== hw/rtl/hptc_pkg.sv =====
// ----------------------------------------------------------------------------
// hptc_pkg
// Shared widths, register indexes and stage types of the heading PID turn
// controller.
// ----------------------------------------------------------------------------
package hptc_pkg;

   localparam int HEADING_W   = 16;
   localparam int TOL_W       = 15;
   localparam int GAIN_W      = 16;
   localparam int DRIVE_W     = 15;
   localparam int ERROR_W     = 16;
   localparam int DERIV_W     = 18;
   localparam int SUM_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_HEADING = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_TOLERANCE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_PROP      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_INTEG     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_DERIV     = 3'd4;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_prop;
      logic [GAIN_W-1:0] gain_integ;
      logic [GAIN_W-1:0] gain_deriv;
   } gains_type;

   typedef struct packed {
      logic                      valid;
      logic                      done;
      logic signed [ERROR_W-1:0] err;
      logic signed [DERIV_W-1:0] deriv;
      logic signed [SUM_W-1:0]   sum;
   } err_stage_type;

   typedef struct packed {
      logic                      valid;
      logic                      done;
      logic signed [DRIVE_W-1:0] drive;
      logic signed [ERROR_W-1:0] err;
   } drive_result_type;

endpackage

// ===== hw/rtl/hptc_modred.sv =====
// ----------------------------------------------------------------------------
// hptc_modred
// Reduces a 16-bit heading modulo the full turn by a short chain of
// conditional subtractions of shifted multiples.
// ----------------------------------------------------------------------------
module hptc_modred #(
   parameter int FULL_TURN = 36000
) (
   input  logic [hptc_pkg::HEADING_W-1:0] heading_raw,
   output logic [hptc_pkg::HEADING_W-1:0] heading_mod
);

   localparam int Span  = 1 << hptc_pkg::HEADING_W;
   localparam int Steps = $clog2((Span + FULL_TURN - 1) / FULL_TURN);
   localparam int RemW  = hptc_pkg::HEADING_W + 2;

   always_comb begin
      logic [RemW-1:0] rem;
      rem = RemW'(heading_raw);
      for (int k = Steps - 1; k >= 0; k--) begin
         if (rem >= RemW'(FULL_TURN << k)) begin
            rem = rem - RemW'(FULL_TURN << k);
         end
      end
      heading_mod = rem[hptc_pkg::HEADING_W-1:0];
   end

endmodule

// ===== hw/rtl/hptc_error.sv =====
// ----------------------------------------------------------------------------
// hptc_error
// Shortest-path heading error, done test, derivative and saturating error
// sum. Holds the controller state and registers the stage result.
// ----------------------------------------------------------------------------
module hptc_error #(
   parameter int FULL_TURN = 36000
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [hptc_pkg::HEADING_W-1:0]  heading_mod,
   input  logic                            new_turn,
   input  logic [hptc_pkg::HEADING_W-1:0]  target_mod,
   input  logic [hptc_pkg::TOL_W-1:0]      stop_tolerance,
   output hptc_pkg::err_stage_type         stage_out
);

   localparam int WideW = hptc_pkg::HEADING_W + 2;
   localparam int MagW  = hptc_pkg::HEADING_W + 1;
   localparam logic signed [WideW-1:0] FullTurnS = WideW'(FULL_TURN);
   localparam logic [MagW-1:0] HalfTurn = MagW'(FULL_TURN / 2);

   logic                                     step;
   logic signed [WideW-1:0]                  diff;
   logic signed [WideW-1:0]                  r_val;
   logic signed [WideW-1:0]                  l_val;
   logic signed [WideW-1:0]                  err_full;
   logic signed [hptc_pkg::ERROR_W-1:0]      err;
   logic [MagW-1:0]                          mag;
   logic                                     done;
   logic signed [hptc_pkg::ERROR_W-1:0]      prev_eff;
   logic signed [hptc_pkg::SUM_W-1:0]        sum_eff;
   logic signed [hptc_pkg::DERIV_W-1:0]      deriv;
   logic signed [hptc_pkg::SUM_W:0]          sum_wide;
   logic signed [hptc_pkg::SUM_W-1:0]        sum_sat;

   logic signed [hptc_pkg::ERROR_W-1:0]      prev_error_ff, prev_error_in;
   logic signed [hptc_pkg::SUM_W-1:0]        error_sum_ff, error_sum_in;
   hptc_pkg::err_stage_type                  stage_ff, stage_in;

   assign step = in_valid && en;

   always_comb begin
      diff     = $signed({2'b00, target_mod}) - $signed({2'b00, heading_mod});
      r_val    = (diff < 0) ? diff + FullTurnS : diff;
      l_val    = (r_val == '0) ? '0 : FullTurnS - r_val;
      err_full = (r_val < l_val) ? r_val : -l_val;
      err      = err_full[hptc_pkg::ERROR_W-1:0];
      mag      = (err_full < 0) ? MagW'(-err_full) : MagW'(err_full);
      done     = mag <= MagW'(stop_tolerance);
      prev_eff = new_turn ? '0 : prev_error_ff;
      sum_eff  = new_turn ? '0 : error_sum_ff;
      deriv    = hptc_pkg::DERIV_W'(err) - hptc_pkg::DERIV_W'(prev_eff);
      sum_wide = (hptc_pkg::SUM_W + 1)'(sum_eff) + (hptc_pkg::SUM_W + 1)'(err);
      if (sum_wide[hptc_pkg::SUM_W] != sum_wide[hptc_pkg::SUM_W-1]) begin
         sum_sat = sum_wide[hptc_pkg::SUM_W] ? {1'b1, {(hptc_pkg::SUM_W-1){1'b0}}}
                                             : {1'b0, {(hptc_pkg::SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[hptc_pkg::SUM_W-1:0];
      end
   end

   always_comb begin
      prev_error_in = prev_error_ff;
      error_sum_in  = error_sum_ff;
      if (step) begin
         prev_error_in = done ? prev_eff : err;
         error_sum_in  = done ? sum_eff  : sum_sat;
      end
      stage_in       = stage_ff;
      if (en) begin
         stage_in.valid = in_valid;
         stage_in.done  = done;
         stage_in.err   = err;
         stage_in.deriv = deriv;
         stage_in.sum   = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff  <= '0;
         error_sum_ff   <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         prev_error_ff  <= prev_error_in;
         error_sum_ff   <= error_sum_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.done  <= stage_in.done;
      stage_ff.err   <= stage_in.err;
      stage_ff.deriv <= stage_in.deriv;
      stage_ff.sum   <= stage_in.sum;
   end

   assign stage_out = stage_ff;

   a_hold_when_done : assert property (@(posedge clock) disable iff (reset)
      (step && done && !new_turn) |=>
         ($stable(prev_error_ff) && $stable(error_sum_ff)))
      else $error("state changed on a done step");

   a_prev_tracks_err : assert property (@(posedge clock) disable iff (reset)
      (step && !done) |=> (prev_error_ff == $past(err)))
      else $error("previous error not updated from error");

   a_short_way : assert property (@(posedge clock) disable iff (reset)
      step |-> (mag <= HalfTurn))
      else $error("error longer than half a turn");

   a_stage_follows_step : assert property (@(posedge clock) disable iff (reset)
      step |=> (stage_ff.valid && (stage_ff.err == prev_error_ff || stage_ff.done)))
      else $error("stage result out of step with state");

endmodule

// ===== hw/rtl/hptc_drive.sv =====
// ----------------------------------------------------------------------------
// hptc_drive
// PID drive: gain products, rounded sum to millivolts, saturation and zero drive when done.
// ----------------------------------------------------------------------------
module hptc_drive #(
   parameter int DRIVE_LIMIT_MV = 12000
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  hptc_pkg::err_stage_type      stage_in,
   input  hptc_pkg::gains_type          gains,
   output hptc_pkg::drive_result_type   result
);

   localparam int GainSW  = hptc_pkg::GAIN_W + 1;
   localparam int ProdPW  = GainSW + hptc_pkg::ERROR_W;
   localparam int ProdIW  = GainSW + hptc_pkg::SUM_W;
   localparam int ProdDW  = GainSW + hptc_pkg::DERIV_W;
   localparam int TotalW  = ProdIW + 3;
   localparam int RndW    = TotalW - 8;
   localparam int FieldHi = (1 << (hptc_pkg::DRIVE_W - 1)) - 1;
   localparam int DriveHi = (DRIVE_LIMIT_MV < FieldHi) ? DRIVE_LIMIT_MV : FieldHi;
   localparam int DriveLo = (DRIVE_LIMIT_MV < FieldHi + 1) ? -DRIVE_LIMIT_MV
                                                           : -(FieldHi + 1);
   localparam logic signed [TotalW-1:0] RoundBias = TotalW'(128);
   localparam logic signed [RndW-1:0]   HiVal     = RndW'(DriveHi);
   localparam logic signed [RndW-1:0]   LoVal     = RndW'(DriveLo);

   logic                                s3_valid_ff, s3_valid_in;
   logic                                s3_done_ff, s3_done_in;
   logic signed [hptc_pkg::ERROR_W-1:0] s3_err_ff, s3_err_in;
   logic signed [ProdPW-1:0]            prod_p_ff, prod_p_in;
   logic signed [ProdIW-1:0]            prod_i_ff, prod_i_in;
   logic signed [ProdDW-1:0]            prod_d_ff, prod_d_in;

   logic                                s4_valid_ff, s4_valid_in;
   logic                                s4_done_ff, s4_done_in;
   logic signed [hptc_pkg::ERROR_W-1:0] s4_err_ff, s4_err_in;
   logic signed [RndW-1:0]              rounded_ff, rounded_in;

   logic signed [TotalW-1:0]            total;
   logic signed [hptc_pkg::DRIVE_W-1:0] drive;

   always_comb begin
      s3_valid_in = s3_valid_ff;
      s3_done_in  = s3_done_ff;
      s3_err_in   = s3_err_ff;
      prod_p_in   = prod_p_ff;
      prod_i_in   = prod_i_ff;
      prod_d_in   = prod_d_ff;
      if (en) begin
         s3_valid_in = stage_in.valid;
         s3_done_in  = stage_in.done;
         s3_err_in   = stage_in.err;
         prod_p_in   = $signed({1'b0, gains.gain_prop})  * stage_in.err;
         prod_i_in   = $signed({1'b0, gains.gain_integ}) * stage_in.sum;
         prod_d_in   = $signed({1'b0, gains.gain_deriv}) * stage_in.deriv;
      end
   end

   always_comb begin
      total = TotalW'(prod_p_ff) + TotalW'(prod_i_ff) + TotalW'(prod_d_ff) + RoundBias;
      s4_valid_in = s4_valid_ff;
      s4_done_in  = s4_done_ff;
      s4_err_in   = s4_err_ff;
      rounded_in  = rounded_ff;
      if (en) begin
         s4_valid_in = s3_valid_ff;
         s4_done_in  = s3_done_ff;
         s4_err_in   = s3_err_ff;
         rounded_in  = RndW'(total >>> 8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
      s3_done_ff <= s3_done_in;
      s3_err_ff  <= s3_err_in;
      prod_p_ff  <= prod_p_in;
      prod_i_ff  <= prod_i_in;
      prod_d_ff  <= prod_d_in;
      s4_done_ff <= s4_done_in;
      s4_err_ff  <= s4_err_in;
      rounded_ff <= rounded_in;
   end

   always_comb begin
      priority if (s4_done_ff) begin
         drive = '0;
      end else if (rounded_ff > HiVal) begin
         drive = hptc_pkg::DRIVE_W'(HiVal);
      end else if (rounded_ff < LoVal) begin
         drive = hptc_pkg::DRIVE_W'(LoVal);
      end else begin
         drive = rounded_ff[hptc_pkg::DRIVE_W-1:0];
      end
   end

   assign result.valid = s4_valid_ff;
   assign result.done  = s4_done_ff;
   assign result.drive = drive;
   assign result.err   = s4_err_ff;

endmodule

// ===== hw/rtl/heading_pid_turn_controller.sv =====
// ----------------------------------------------------------------------------
// heading_pid_turn_controller
// Heading PID turn controller with wrapped shortest-path error.
// ----------------------------------------------------------------------------
// One heading sample per transaction; one result per sample, in order. The
// block takes a new transaction every cycle while the result side keeps up;
// each sample passes through the input register, heading reduction, error
// and state update, gain products, rounding, then the result register. The
// rate is set by the error stage, which updates the previous error and the
// saturating error sum as each sample passes. A stalled result holds the
// whole pipeline. Gains and tolerance are read by transactions in flight,
// so write them only while the block is idle.
// ----------------------------------------------------------------------------
module heading_pid_turn_controller #(
   parameter int FULL_TURN      = 36000,
   parameter int DRIVE_LIMIT_MV = 12000
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: [15:0] heading_sample, [16] new_turn, [23:17] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hptc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // response: [14:0] drive_mv, [15] done_res, [31:16] turn_error
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hptc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hptc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hptc_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic                                en;
   logic                                csr_write;
   logic [hptc_pkg::HEADING_W-1:0]      target_reduced;
   logic [hptc_pkg::HEADING_W-1:0]      heading_reduced;

   logic [hptc_pkg::HEADING_W-1:0]      target_mod_ff, target_mod_in;
   logic [hptc_pkg::TOL_W-1:0]          stop_tolerance_ff, stop_tolerance_in;
   hptc_pkg::gains_type                 gains_ff, gains_in;

   logic                                s0_valid_ff, s0_valid_in;
   logic [hptc_pkg::HEADING_W-1:0]      s0_heading_ff, s0_heading_in;
   logic                                s0_new_turn_ff, s0_new_turn_in;
   logic                                s1_valid_ff, s1_valid_in;
   logic [hptc_pkg::HEADING_W-1:0]      s1_heading_ff, s1_heading_in;
   logic                                s1_new_turn_ff, s1_new_turn_in;

   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [hptc_pkg::RSP_DATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   hptc_pkg::err_stage_type             err_stage;
   hptc_pkg::drive_result_type          drive_res;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   hptc_modred #(.FULL_TURN(FULL_TURN)) u_target_red (
      .heading_raw (csr_data[hptc_pkg::HEADING_W-1:0]),
      .heading_mod (target_reduced)
   );

   hptc_modred #(.FULL_TURN(FULL_TURN)) u_heading_red (
      .heading_raw (s0_heading_ff),
      .heading_mod (heading_reduced)
   );

   always_comb begin
      target_mod_in     = target_mod_ff;
      stop_tolerance_in = stop_tolerance_ff;
      gains_in          = gains_ff;
      if (csr_write) begin
         unique case (csr_index)
            hptc_pkg::CSR_TARGET_HEADING: target_mod_in = target_reduced;
            hptc_pkg::CSR_STOP_TOLERANCE: stop_tolerance_in = csr_data[hptc_pkg::TOL_W-1:0];
            hptc_pkg::CSR_GAIN_PROP:      gains_in.gain_prop  = csr_data;
            hptc_pkg::CSR_GAIN_INTEG:     gains_in.gain_integ = csr_data;
            hptc_pkg::CSR_GAIN_DERIV:     gains_in.gain_deriv = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      s0_valid_in    = s0_valid_ff;
      s0_heading_in  = s0_heading_ff;
      s0_new_turn_in = s0_new_turn_ff;
      s1_valid_in    = s1_valid_ff;
      s1_heading_in  = s1_heading_ff;
      s1_new_turn_in = s1_new_turn_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      if (en) begin
         s0_valid_in    = req_tvalid;
         s0_heading_in  = req_tdata[hptc_pkg::HEADING_W-1:0];
         s0_new_turn_in = req_tdata[hptc_pkg::HEADING_W];
         s1_valid_in    = s0_valid_ff;
         s1_heading_in  = heading_reduced;
         s1_new_turn_in = s0_new_turn_ff;
         rsp_tvalid_in  = drive_res.valid;
         rsp_tdata_in   = {drive_res.err, drive_res.done, drive_res.drive};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_mod_ff           <= '0;
         stop_tolerance_ff       <= hptc_pkg::TOL_W'(100);
         gains_ff.gain_prop      <= hptc_pkg::GAIN_W'(384);
         gains_ff.gain_integ     <= '0;
         gains_ff.gain_deriv     <= hptc_pkg::GAIN_W'(2560);
         s0_valid_ff             <= 1'b0;
         s1_valid_ff             <= 1'b0;
         rsp_tvalid_ff           <= 1'b0;
      end else begin
         target_mod_ff           <= target_mod_in;
         stop_tolerance_ff       <= stop_tolerance_in;
         gains_ff                <= gains_in;
         s0_valid_ff             <= s0_valid_in;
         s1_valid_ff             <= s1_valid_in;
         rsp_tvalid_ff           <= rsp_tvalid_in;
      end
      s0_heading_ff  <= s0_heading_in;
      s0_new_turn_ff <= s0_new_turn_in;
      s1_heading_ff  <= s1_heading_in;
      s1_new_turn_ff <= s1_new_turn_in;
      rsp_tdata_ff   <= rsp_tdata_in;
   end

   hptc_error #(.FULL_TURN(FULL_TURN)) u_error (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (s1_valid_ff),
      .heading_mod    (s1_heading_ff),
      .new_turn       (s1_new_turn_ff),
      .target_mod     (target_mod_ff),
      .stop_tolerance (stop_tolerance_ff),
      .stage_out      (err_stage)
   );

   hptc_drive #(.DRIVE_LIMIT_MV(DRIVE_LIMIT_MV)) u_drive (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .stage_in (err_stage),
      .gains    (gains_ff),
      .result   (drive_res)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
